[rtl/touch_panel_spi_poller_top_assert.svh]
// Assertion macros for the touch panel SPI poller.
`ifndef TOUCH_PANEL_SPI_POLLER_TOP_ASSERT_SVH
`define TOUCH_PANEL_SPI_POLLER_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define TSP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("touch panel poller: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define TSP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("touch panel poller: next-cycle check failed");
`else
`define TSP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TSP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/tsp_pkg.sv]
// Types, codes and constants shared by the touch panel SPI poller.
`default_nettype none
package tsp_pkg;

  localparam int unsigned StepW   = 3;
  localparam int unsigned SampleW = 12;
  localparam int unsigned CfgW    = 16;

  localparam logic [StepW-1:0] STEP_IDLE = 3'd0;
  localparam logic [StepW-1:0] STEP_LAST = 3'd7;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  localparam logic REG_INHIBIT   = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam logic [15:0]        INHIBIT_RESET   = 16'd0;
  localparam logic [SampleW-1:0] THRESHOLD_RESET = 12'd5;

  localparam logic [7:0] TX_START   = 8'hB1;
  localparam logic [7:0] TX_READ_X  = 8'h91;
  localparam logic [7:0] TX_READ_Y  = 8'hD0;
  localparam logic [7:0] TX_FILL    = 8'h00;

  typedef struct packed {
    logic       command;
    logic       irq_level;
    logic [7:0] rx_byte;
  } tsp_in_t;

  typedef struct packed {
    logic               tx_valid;
    logic [7:0]         tx_byte;
    logic               select_active;
    logic               report_valid;
    logic               report_pressed;
    logic [SampleW-1:0] x_pos;
    logic [SampleW-1:0] y_pos;
    logic [SampleW-1:0] z_pos;
    logic               pressed_now;
  } tsp_out_t;

  // Command byte sent at position k of the seven-byte transfer.
  function automatic logic [7:0] tx_seq(input logic [StepW-1:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = TX_START;
      3'd2:    b = TX_READ_X;
      3'd4:    b = TX_READ_Y;
      default: b = TX_FILL;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

[rtl/touch_panel_spi_poller_top.sv]
// Top level of the touch panel SPI poller: state update and output register.
//
// Usage: the input channel (in_valid/in_ready/in_data) carries one word per
// event: either a 1 ms tick with the pen interrupt level, or a byte received
// over SPI in reply to the byte last sent. Every input word yields exactly one
// output word on out_valid/out_ready/out_data, telling whether to transmit a
// byte, the chip select level, any press or release report, and the latest
// x, y and z samples.
// Output valid rises in the cycle after an input word is accepted.
// Throughput: one word per cycle while the receiver keeps up; the state update
// and the result are a short single pass of logic into the output register.
// When the receiver stalls, the output register holds its word and in_ready
// drops only while that word is still waiting and not being taken this cycle.
// Reset (rst, synchronous, active high) clears the press state, transfer step,
// countdown and samples; inhibit_ticks returns to 0, press_threshold to 5. The
// user writes configuration via cfg_wr_en, cfg_addr and cfg_wdata while the
// block is idle (not enforced); 0 is inhibit_ticks, 1 the threshold.
`default_nettype none
module touch_panel_spi_poller_top (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_wr_en,
  input  wire logic                    cfg_addr,
  input  wire logic [tsp_pkg::CfgW-1:0] cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire tsp_pkg::tsp_in_t        in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output tsp_pkg::tsp_out_t            out_data
);
  import tsp_pkg::*;

  `include "touch_panel_spi_poller_top_assert.svh"

  // Configuration registers
  logic [15:0]        inhibit_ticks;
  logic [SampleW-1:0] press_threshold;

  // Poller state
  logic               pressed_flag,   pressed_flag_next;
  logic [StepW-1:0]   sequence_step,  sequence_step_next;
  logic               first_sample,   first_sample_next;
  logic [15:0]        wait_countdown, wait_countdown_next;
  logic [SampleW-1:0] pressure_value, pressure_value_next;
  logic [SampleW-1:0] x_value,        x_value_next;
  logic [SampleW-1:0] y_value,        y_value_next;

  tsp_out_t result;
  logic     in_accept;
  logic     ok;
  logic     start;
  logic [SampleW-1:0] hi_part;
  logic [3:0]         lo_part;

  // Take a new word whenever the output slot is free or being emptied.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign hi_part = {in_data.rx_byte, 4'h0};
  assign lo_part = in_data.rx_byte[7:4];

  always_ff @(posedge clk) begin
    if (rst) begin
      inhibit_ticks   <= INHIBIT_RESET;
      press_threshold <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_addr == REG_INHIBIT) begin
        inhibit_ticks <= cfg_wdata;
      end else begin
        press_threshold <= cfg_wdata[SampleW-1:0];
      end
    end
  end

  always_comb begin
    pressed_flag_next   = pressed_flag;
    sequence_step_next  = sequence_step;
    first_sample_next   = first_sample;
    wait_countdown_next = wait_countdown;
    pressure_value_next = pressure_value;
    x_value_next        = x_value;
    y_value_next        = y_value;
    start               = 1'b0;
    ok                  = 1'b0;
    result              = '0;

    if (in_data.command == CMD_TICK) begin
      if (sequence_step != STEP_IDLE) begin
        // Keep counting during a transfer, hold at zero.
        if (wait_countdown != 16'd0) begin
          wait_countdown_next = wait_countdown - 16'd1;
        end
      end else if (pressed_flag) begin
        if (wait_countdown == 16'd0) begin
          start             = 1'b1;
          first_sample_next = 1'b0;
        end else begin
          wait_countdown_next = wait_countdown - 16'd1;
        end
      end else if (!in_data.irq_level) begin
        pressed_flag_next = 1'b1;
        first_sample_next = 1'b1;
        start             = 1'b1;
      end
      if (start) begin
        wait_countdown_next = inhibit_ticks;
        sequence_step_next  = 3'd1;
        result.tx_valid     = 1'b1;
        result.tx_byte      = TX_START;
      end
    end else if (sequence_step != STEP_IDLE) begin
      // Replies to bytes two to seven carry z, x and y, high part first.
      case (sequence_step)
        3'd2:    pressure_value_next = hi_part;
        3'd3:    pressure_value_next = {pressure_value[SampleW-1:4], lo_part};
        3'd4:    x_value_next        = hi_part;
        3'd5:    x_value_next        = {x_value[SampleW-1:4], lo_part};
        3'd6:    y_value_next        = hi_part;
        3'd7:    y_value_next        = {y_value[SampleW-1:4], lo_part};
        default: ;
      endcase
      if (sequence_step != STEP_LAST) begin
        result.tx_valid    = 1'b1;
        result.tx_byte     = tx_seq(sequence_step);
        sequence_step_next = sequence_step + 3'd1;
      end else begin
        ok                 = pressure_value_next >= press_threshold;
        sequence_step_next = STEP_IDLE;
        if (first_sample) begin
          // First sample after a press never releases.
          first_sample_next = 1'b0;
          if (ok) begin
            result.report_valid   = 1'b1;
            result.report_pressed = 1'b1;
          end
        end else begin
          if (!ok || in_data.irq_level) begin
            pressed_flag_next = 1'b0;
          end
          result.report_valid   = 1'b1;
          result.report_pressed = pressed_flag_next;
        end
      end
    end

    result.select_active = sequence_step_next != STEP_IDLE;
    result.x_pos         = x_value_next;
    result.y_pos         = y_value_next;
    result.z_pos         = pressure_value_next;
    result.pressed_now   = pressed_flag_next;
  end

  // State registers: advance only on an accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_flag   <= 1'b0;
      sequence_step  <= STEP_IDLE;
      first_sample   <= 1'b0;
      wait_countdown <= 16'd0;
      pressure_value <= '0;
      x_value        <= '0;
      y_value        <= '0;
    end else if (in_accept) begin
      pressed_flag   <= pressed_flag_next;
      sequence_step  <= sequence_step_next;
      first_sample   <= first_sample_next;
      wait_countdown <= wait_countdown_next;
      pressure_value <= pressure_value_next;
      x_value        <= x_value_next;
      y_value        <= y_value_next;
    end
  end

  // Output register: hold the word while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result;
    end
  end

  `TSP_ASSERT_IMP(a_xfer_needs_press, clk, rst, sequence_step != STEP_IDLE, pressed_flag)
  `TSP_ASSERT_IMP(a_tx_with_select, clk, rst, out_valid && out_data.tx_valid,
                  out_data.select_active)
  `TSP_ASSERT_IMP(a_report_no_tx, clk, rst, out_valid && out_data.report_valid,
                  !out_data.tx_valid && !out_data.select_active)
  `TSP_ASSERT_NXT(a_last_byte_ends, clk, rst,
                  in_accept && in_data.command == CMD_BYTE && sequence_step == STEP_LAST,
                  sequence_step == STEP_IDLE && out_valid)

endmodule
`default_nettype wire
